@@ rtl/uniform_grid_object_binning_top_assert.svh @@
// assertion macros for the grid binning block
`ifndef UNIFORM_GRID_OBJECT_BINNING_TOP_ASSERT_SVH
`define UNIFORM_GRID_OBJECT_BINNING_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define UGB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define UGB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
    else $error("%m failed");
`else
`define UGB_ASSERT(label, clk, rst_n, prop)
`define UGB_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ rtl/ugob_pkg.sv @@
package ugob_pkg;
  localparam int unsigned MaxCells   = 1024;
  localparam int unsigned CellSlots  = 16;
  localparam int unsigned CellW      = $clog2(MaxCells);
  localparam int unsigned SlotW      = $clog2(CellSlots);
  localparam int unsigned NumPoints  = 5;

  localparam logic [1:0] RegWidth   = 2'd0;
  localparam logic [1:0] RegHeight  = 2'd1;
  localparam logic [1:0] RegSpacing = 2'd2;

  localparam logic OpPlace = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_CLEAR  = 11'b00000000010,
    ST_DIVR   = 11'b00000000100,
    ST_DIVN   = 11'b00000001000,
    ST_ERASE  = 11'b00000010000,
    ST_PDIV   = 11'b00000100000,
    ST_IDX    = 11'b00001000000,
    ST_SCAN   = 11'b00010000000,
    ST_ACK    = 11'b00100000000,
    ST_QOUT   = 11'b01000000000,
    ST_QWAIT  = 11'b10000000000
  } state_e;
endpackage

@@ rtl/uniform_grid_object_binning_top.sv @@
// channel   | direction | signals
// command   | in        | start_i / busy_o, operation_i pos_x_i pos_y_i radius_i object_id_i
// config    | in        | cfg_valid_i / cfg_ready_o, cfg_index_i cfg_data_i
// result    | out       | result_valid_o, slot_number_o slot_object_o out_of_range_o
//           |           | is_place_ack_o last_o
// after reset a clearing pass writes one cell row (16 slots) per cycle
// every item first runs two 21-step shift-subtract divisions for rows and columns
// a place with a nonzero id then erases 1024 rows (one read-modify-write a cycle), runs ten
// 21-step divisions for the five cell coordinate pairs, reads and writes each point's row,
// then gives the ack beat; a query gives 16 beats or one out-of-range beat
// results cannot be stalled; busy_o drops in the cycle that carries the last result beat
module uniform_grid_object_binning_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] radius_i,
  input  logic [15:0] object_id_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [3:0]  slot_number_o,
  output logic [15:0] slot_object_o,
  output logic        out_of_range_o,
  output logic        is_place_ack_o,
  output logic        last_o
);
  `include "uniform_grid_object_binning_top_assert.svh"

  localparam int unsigned CW = ugob_pkg::CellW;
  localparam int unsigned SW = ugob_pkg::SlotW;
  localparam int unsigned RowW = ugob_pkg::CellSlots * 16;

  ugob_pkg::state_e state_q;

  logic [14:0] width_q, height_q;
  logic [12:0] spacing_q;
  logic        op_q;
  logic [15:0] px_q, py_q, rad_q, id_q;

  // memory, one row per cell
  logic [RowW-1:0] mem [ugob_pkg::MaxCells];
  logic [RowW-1:0] rdata_q;
  logic            mem_we;
  logic [CW-1:0]   mem_waddr, mem_raddr;
  logic [RowW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  // shared shift-subtract divider, unsigned 21-bit dividend / 17-bit divisor
  logic [20:0] dv_num_q, dv_quo_q;
  logic [20:0] dv_rem_q;
  logic [16:0] dv_den_q;
  logic [4:0]  dv_cnt_q;
  logic [21:0] dv_trial;
  always_comb dv_trial = {dv_rem_q, dv_num_q[20]} - {5'd0, dv_den_q};

  logic [CW:0]   cnt_q;       // sweep / scan counter
  logic [2:0]    pt_q;        // point index
  logic [14:0]   rows_q;
  logic [16:0]   ncell_q;     // cell count clipped to MaxCells
  logic [14:0]   cols_q;
  logic signed [21:0] cx_q, cy_q;  // signed cell coordinates
  logic signed [37:0] idx_q [ugob_pkg::NumPoints];
  logic [ugob_pkg::NumPoints-1:0] ok_q;
  logic          negx_q;
  logic          phase_q;     // 0 x coord / rows, 1 y coord / columns

  logic [12:0] sp_eff;
  always_comb sp_eff = (spacing_q == 13'd0) ? 13'd1 : spacing_q;

  // point coordinates in sixteenths
  logic signed [21:0] ptx, pty;
  always_comb begin
    ptx = $signed({{2{px_q[15]}}, px_q, 4'd0});
    pty = $signed({{2{py_q[15]}}, py_q, 4'd0});
    case (pt_q)
      3'd1: ptx = ptx + $signed({6'd0, rad_q});
      3'd2: ptx = ptx - $signed({6'd0, rad_q});
      3'd3: pty = pty + $signed({6'd0, rad_q});
      3'd4: pty = pty - $signed({6'd0, rad_q});
      default: ;
    endcase
  end

  logic signed [21:0] dv_in;
  logic [20:0] dv_mag;
  always_comb begin
    dv_in = phase_q ? pty : ptx;
    dv_mag = dv_in[21] ? 21'(-dv_in) : dv_in[20:0];
  end
  // floored signed quotient from magnitude result
  logic signed [21:0] fq;
  always_comb begin
    if (negx_q) fq = -$signed({1'b0, dv_quo_q}) - ((dv_rem_q != 21'd0) ? 22'sd1 : 22'sd0);
    else        fq = $signed({1'b0, dv_quo_q});
  end

  logic [CW-1:0] cur_cell;
  logic signed [37:0] cur_idx;
  always_comb begin
    cur_idx = idx_q[pt_q];
    cur_cell = cur_idx[CW-1:0];
  end

  // row update for scan
  logic [RowW-1:0] ins_row;
  logic            hit, empt;
  always_comb begin
    ins_row = rdata_q;
    hit = 1'b0;
    empt = 1'b0;
    for (int j = 0; j < ugob_pkg::CellSlots; j++) begin
      if (!hit && !empt) begin
        if (rdata_q[j*16 +: 16] == id_q) hit = 1'b1;
        else if (rdata_q[j*16 +: 16] == 16'd0) begin
          empt = 1'b1;
          ins_row[j*16 +: 16] = id_q;
        end
      end
    end
  end

  logic [RowW-1:0] era_row;
  always_comb begin
    for (int j = 0; j < ugob_pkg::CellSlots; j++)
      era_row[j*16 +: 16] = (rdata_q[j*16 +: 16] == id_q) ? 16'd0 : rdata_q[j*16 +: 16];
  end

  logic signed [37:0] mul_res;
  always_comb mul_res = cx_q * $signed({1'b0, rows_q});

  logic idx_ok;
  always_comb idx_ok = !cur_idx[37] && (cur_idx < $signed({21'd0, ncell_q}));

  logic start_acc;
  always_comb start_acc = start_i && !busy_o;

  assign busy_o = (state_q != ugob_pkg::ST_IDLE);
  // no config beat at the edge that takes a command
  assign cfg_ready_o = ((state_q == ugob_pkg::ST_IDLE) && !start_i) ||
                       (state_q == ugob_pkg::ST_CLEAR);

  logic last_slot;
  always_comb last_slot = (cnt_q[SW-1:0] == SW'(ugob_pkg::CellSlots - 1));

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cnt_q[CW-1:0];
    mem_wdata = '0;
    mem_raddr = cnt_q[CW-1:0];
    case (state_q)
      ugob_pkg::ST_CLEAR: mem_we = 1'b1;
      // row 0 is read ahead for the first erase cycle
      ugob_pkg::ST_DIVR, ugob_pkg::ST_DIVN: mem_raddr = '0;
      ugob_pkg::ST_ERASE: begin
        mem_raddr = cnt_q[CW-1:0] + CW'(1);
        mem_waddr = cnt_q[CW-1:0];
        mem_we = 1'b1;
        mem_wdata = era_row;
      end
      ugob_pkg::ST_SCAN: begin
        mem_raddr = cur_cell;
        mem_waddr = cur_cell;
        mem_we = cnt_q[0] && ok_q[pt_q] && empt;
        mem_wdata = ins_row;
      end
      ugob_pkg::ST_QWAIT, ugob_pkg::ST_QOUT: mem_raddr = cur_cell;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ugob_pkg::ST_CLEAR;
      width_q <= 15'd640;
      height_q <= 15'd480;
      spacing_q <= 13'd32;
      cnt_q <= '0;
      pt_q <= '0;
      phase_q <= 1'b0;
      dv_cnt_q <= '0;
      ok_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (state_q == ugob_pkg::ST_ACK) || (state_q == ugob_pkg::ST_QOUT) ||
                        ((state_q == ugob_pkg::ST_QWAIT) && !idx_ok);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ugob_pkg::RegWidth:   width_q <= cfg_data_i;
          ugob_pkg::RegHeight:  height_q <= cfg_data_i;
          ugob_pkg::RegSpacing: spacing_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      // divider step runs whenever the counter is nonzero
      if (dv_cnt_q != 5'd0) begin
        dv_cnt_q <= dv_cnt_q - 5'd1;
        dv_num_q <= {dv_num_q[19:0], 1'b0};
        if (!dv_trial[21]) begin
          dv_rem_q <= dv_trial[20:0];
          dv_quo_q <= {dv_quo_q[19:0], 1'b1};
        end else begin
          dv_rem_q <= {dv_rem_q[19:0], dv_num_q[20]};
          dv_quo_q <= {dv_quo_q[19:0], 1'b0};
        end
      end
      case (state_q)
        ugob_pkg::ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[CW]) state_q <= ugob_pkg::ST_IDLE;
        end
        ugob_pkg::ST_IDLE: if (start_acc) begin
          op_q <= operation_i;
          px_q <= pos_x_i;
          py_q <= pos_y_i;
          rad_q <= (operation_i == ugob_pkg::OpQuery) ? 16'd0 : radius_i;
          id_q <= object_id_i;
          dv_num_q <= {6'd0, height_q};
          dv_den_q <= {4'd0, sp_eff};
          dv_rem_q <= '0;
          dv_quo_q <= '0;
          dv_cnt_q <= 5'd21;
          pt_q <= '0;
          phase_q <= 1'b0;
          state_q <= ugob_pkg::ST_DIVR;
        end
        ugob_pkg::ST_DIVR: if (dv_cnt_q == 5'd0) begin
          if (!phase_q) begin
            rows_q <= dv_quo_q[14:0];
            dv_num_q <= {6'd0, width_q};
            dv_rem_q <= '0;
            dv_quo_q <= '0;
            dv_cnt_q <= 5'd21;
            phase_q <= 1'b1;
          end else begin
            cols_q <= dv_quo_q[14:0];
            phase_q <= 1'b0;
            state_q <= ugob_pkg::ST_DIVN;
          end
        end
        ugob_pkg::ST_DIVN: begin
          // one 15x15 product, clipped
          if ((32'(cols_q) * 32'(rows_q)) > 32'(ugob_pkg::MaxCells))
            ncell_q <= 17'(ugob_pkg::MaxCells);
          else ncell_q <= 17'(cols_q * rows_q);
          cnt_q <= '0;
          if (op_q == ugob_pkg::OpPlace && id_q != 16'd0) state_q <= ugob_pkg::ST_ERASE;
          else state_q <= ugob_pkg::ST_PDIV;
          pt_q <= '0;
          phase_q <= 1'b0;
          dv_cnt_q <= '0;
        end
        ugob_pkg::ST_ERASE: begin
          if (cnt_q[CW-1:0] == {CW{1'b1}}) begin
            state_q <= ugob_pkg::ST_PDIV;
            cnt_q <= '0;
          end else cnt_q <= cnt_q + 1'b1;
        end
        ugob_pkg::ST_PDIV: begin
          // launch a division of the current coordinate
          negx_q <= dv_in[21];
          dv_num_q <= dv_mag;
          dv_den_q <= {sp_eff, 4'd0};
          dv_rem_q <= '0;
          dv_quo_q <= '0;
          dv_cnt_q <= 5'd21;
          state_q <= ugob_pkg::ST_IDX;
        end
        ugob_pkg::ST_IDX: if (dv_cnt_q == 5'd0) begin
          if (!phase_q) begin
            cx_q <= fq;
            phase_q <= 1'b1;
            state_q <= ugob_pkg::ST_PDIV;
          end else if (!cnt_q[0]) begin
            cy_q <= fq;
            cnt_q <= (CW+1)'(1);
          end else begin
            idx_q[pt_q] <= mul_res + 38'(cy_q);
            phase_q <= 1'b0;
            cnt_q <= '0;
            if (op_q == ugob_pkg::OpQuery) state_q <= ugob_pkg::ST_QWAIT;
            else if (pt_q == 3'(ugob_pkg::NumPoints - 1) || id_q == 16'd0) begin
              pt_q <= '0;
              state_q <= (id_q == 16'd0) ? ugob_pkg::ST_ACK : ugob_pkg::ST_SCAN;
            end else begin
              pt_q <= pt_q + 3'd1;
              state_q <= ugob_pkg::ST_PDIV;
            end
          end
        end
        ugob_pkg::ST_SCAN: begin
          // reads the row, then writes the id into its first free slot; validity checked per point
          if (!cnt_q[0]) begin
            ok_q[pt_q] <= idx_ok;
            cnt_q <= (CW+1)'(1);
          end else begin
            cnt_q <= '0;
            if (pt_q == 3'(ugob_pkg::NumPoints - 1)) state_q <= ugob_pkg::ST_ACK;
            else pt_q <= pt_q + 3'd1;
          end
        end
        ugob_pkg::ST_ACK: begin
          slot_number_o <= '0;
          slot_object_o <= '0;
          out_of_range_o <= 1'b0;
          is_place_ack_o <= 1'b1;
          last_o <= 1'b1;
          state_q <= ugob_pkg::ST_IDLE;
        end
        ugob_pkg::ST_QWAIT: begin
          cnt_q <= '0;
          if (!idx_ok) begin
            slot_number_o <= '0;
            slot_object_o <= '0;
            out_of_range_o <= 1'b1;
            is_place_ack_o <= 1'b0;
            last_o <= 1'b1;
            state_q <= ugob_pkg::ST_IDLE;
          end else state_q <= ugob_pkg::ST_QOUT;
        end
        ugob_pkg::ST_QOUT: begin
          slot_number_o <= 4'(cnt_q[SW-1:0]);
          slot_object_o <= rdata_q[cnt_q[SW-1:0]*16 +: 16];
          out_of_range_o <= 1'b0;
          is_place_ack_o <= 1'b0;
          last_o <= last_slot;
          cnt_q <= cnt_q + 1'b1;
          if (last_slot) state_q <= ugob_pkg::ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  // no beat right after an accept; the block is free again once the last beat is out
  `UGB_ASSERT(a_no_start_result, clk_i, rst_ni, !(result_valid_o && $past(start_acc)))
  `UGB_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, result_valid_o && last_o, !busy_o || $past(start_i))
  `UGB_ASSERT(a_ack_flags, clk_i, rst_ni, !(result_valid_o && is_place_ack_o && out_of_range_o))
endmodule

@@ tb/sv/ugob_checker.sv @@
`timescale 1ns / 1ps

module ugob_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic        operation_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] radius_i,
  input  logic [15:0] object_id_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        result_valid_o,
  input  logic [3:0]  slot_number_o,
  input  logic [15:0] slot_object_o,
  input  logic        out_of_range_o,
  input  logic        is_place_ack_o,
  input  logic        last_o,
  output int          errors_o,
  output int          pending_o,
  output int          beats_o,
  output int          oor_beats_o
);

  typedef struct packed {
    logic [3:0]  num;
    logic [15:0] obj;
    logic        oor;
    logic        ack;
    logic        last;
  } beat_t;

  logic [15:0] grid_ids [ugob_pkg::MaxCells*ugob_pkg::CellSlots];
  longint      win_w, win_h, spacing;
  beat_t       beat_q [$];

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint eff_spacing();
    return (spacing == 0) ? 1 : spacing;
  endfunction

  function automatic longint num_cells();
    longint n;
    n = (win_w / eff_spacing()) * (win_h / eff_spacing());
    return (n > ugob_pkg::MaxCells) ? ugob_pkg::MaxCells : n;
  endfunction

  // coordinates in sixteenths of a unit
  function automatic longint cell_of(longint x16, longint y16);
    longint s;
    s = eff_spacing();
    return fdiv(x16, 16 * s) * (win_h / s) + fdiv(y16, 16 * s);
  endfunction

  task automatic bin_object(longint x16, longint y16, longint r, logic [15:0] id);
    longint pts [ugob_pkg::NumPoints];
    longint n;
    n = num_cells();
    for (int i = 0; i < ugob_pkg::MaxCells * ugob_pkg::CellSlots; i++)
      if (grid_ids[i] == id) grid_ids[i] = '0;
    pts[0] = cell_of(x16, y16);
    pts[1] = cell_of(x16 + r, y16);
    pts[2] = cell_of(x16 - r, y16);
    pts[3] = cell_of(x16, y16 + r);
    pts[4] = cell_of(x16, y16 - r);
    for (int i = 0; i < ugob_pkg::NumPoints; i++) begin
      if (pts[i] >= 0 && pts[i] < n) begin
        for (int j = 0; j < ugob_pkg::CellSlots; j++) begin
          if (grid_ids[pts[i]*ugob_pkg::CellSlots+j] == id) break;
          if (grid_ids[pts[i]*ugob_pkg::CellSlots+j] == '0) begin
            grid_ids[pts[i]*ugob_pkg::CellSlots+j] = id;
            break;
          end
        end
      end
    end
  endtask

  task automatic predict_item();
    longint x16, y16, c;
    beat_t  b;
    x16 = longint'($signed(pos_x_i)) * 16;
    y16 = longint'($signed(pos_y_i)) * 16;
    b = '0;
    if (operation_i == ugob_pkg::OpPlace) begin
      if (object_id_i != '0) bin_object(x16, y16, longint'(radius_i), object_id_i);
      b.ack  = 1'b1;
      b.last = 1'b1;
      beat_q.push_back(b);
    end else begin
      c = cell_of(x16, y16);
      if (c < 0 || c >= num_cells()) begin
        b.oor  = 1'b1;
        b.last = 1'b1;
        beat_q.push_back(b);
      end else begin
        for (int k = 0; k < ugob_pkg::CellSlots && k < 16; k++) begin
          b.num  = k[3:0];
          b.obj  = grid_ids[c*ugob_pkg::CellSlots+k];
          b.last = (k == ugob_pkg::CellSlots - 1 || k == 15);
          beat_q.push_back(b);
        end
      end
    end
  endtask

  task automatic check_beat();
    beat_t e;
    if (beat_q.size() == 0) begin
      $display("%0t: result beat with nothing expected (slot %0d obj %h)",
               $time, slot_number_o, slot_object_o);
      errors_o++;
      return;
    end
    e = beat_q.pop_front();
    beats_o++;
    if (e.oor) oor_beats_o++;
    if (slot_number_o !== e.num) begin
      $display("%0t: slot_number expected %0d actual %0d", $time, e.num, slot_number_o);
      errors_o++;
    end
    if (slot_object_o !== e.obj) begin
      $display("%0t: slot_object expected %h actual %h", $time, e.obj, slot_object_o);
      errors_o++;
    end
    if (out_of_range_o !== e.oor) begin
      $display("%0t: out_of_range expected %b actual %b", $time, e.oor, out_of_range_o);
      errors_o++;
    end
    if (is_place_ack_o !== e.ack) begin
      $display("%0t: is_place_ack expected %b actual %b", $time, e.ack, is_place_ack_o);
      errors_o++;
    end
    if (last_o !== e.last) begin
      $display("%0t: last expected %b actual %b", $time, e.last, last_o);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ugob_pkg::MaxCells * ugob_pkg::CellSlots; i++) grid_ids[i] = '0;
      win_w       = 640;
      win_h       = 480;
      spacing     = 32;
      beat_q.delete();
      errors_o    = 0;
      beats_o     = 0;
      oor_beats_o = 0;
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ugob_pkg::RegWidth:   win_w = longint'(cfg_data_i);
          ugob_pkg::RegHeight:  win_h = longint'(cfg_data_i);
          ugob_pkg::RegSpacing: spacing = longint'(cfg_data_i[12:0]);
          default: ;
        endcase
      end
      if (result_valid_o) check_beat();
      if (start_i && !busy_o) predict_item();
      pending_o = beat_q.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        operation_i;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic [15:0] radius_i;
  logic [15:0] object_id_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [14:0] cfg_data_i;
  logic        result_valid_o;
  logic [3:0]  slot_number_o;
  logic [15:0] slot_object_o;
  logic        out_of_range_o;
  logic        is_place_ack_o;
  logic        last_o;

  int errors, pending, beats, oor_beats;
  int n_items, cycles;
  int burst_left;
  int cur_w, cur_h, cur_sp;

  localparam int CycleLimit = 3000000;

  uniform_grid_object_binning_top dut (.*);

  ugob_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .pos_x_i, .pos_y_i,
    .radius_i, .object_id_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .result_valid_o, .slot_number_o, .slot_object_o,
    .out_of_range_o, .is_place_ack_o, .last_o,
    .errors_o(errors), .pending_o(pending), .beats_o(beats),
    .oor_beats_o(oor_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic op, int x, int y, int r, int id);
    // random gaps between bursts
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    burst_left--;
    start_i     = 1'b1;
    operation_i = op;
    pos_x_i     = x[15:0];
    pos_y_i     = y[15:0];
    radius_i    = r[15:0];
    object_id_i = id[15:0];
    do @(posedge clk_i); while (busy_o);
    n_items++;
    @(negedge clk_i);
    if (burst_left == 0) start_i = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, int val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val[14:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_grid(int w, int h, int sp);
    settle();
    cfg_write(ugob_pkg::RegWidth, w);
    cfg_write(ugob_pkg::RegHeight, h);
    cfg_write(ugob_pkg::RegSpacing, sp);
    cur_w  = w;
    cur_h  = h;
    cur_sp = (sp == 0) ? 1 : sp;
  endtask

  task automatic random_item();
    int x, y, r, id;
    logic op;
    if ($urandom_range(0, 9) == 0) begin
      // noise over the whole field ranges
      send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
    end else begin
      op = ($urandom_range(0, 4) < 2) ? ugob_pkg::OpQuery : ugob_pkg::OpPlace;
      x  = $urandom_range(0, cur_w + 2 * cur_sp) - cur_sp;
      y  = $urandom_range(0, cur_h + 2 * cur_sp) - cur_sp;
      r  = $urandom_range(0, 32 * cur_sp);
      if (r > 65535) r = $urandom_range(0, 65535);
      id = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 24);
      if (x > 32767) x = 32767;
      if (y > 32767) y = 32767;
      send_item(op, x, y, r, id);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operation_i = ugob_pkg::OpPlace;
    pos_x_i     = '0;
    pos_y_i     = '0;
    radius_i    = '0;
    object_id_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ugob_pkg::RegWidth;
    cfg_data_i  = '0;
    cycles      = 0;
    n_items     = 0;
    burst_left  = 0;
    cur_w       = 640;
    cur_h       = 480;
    cur_sp      = 32;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part on the reset grid
    send_item(ugob_pkg::OpPlace, 0, 0, 0, 1);
    send_item(ugob_pkg::OpPlace, 639, 479, 65535, 16'hffff);
    send_item(ugob_pkg::OpPlace, 100, 100, 32 * 16, 2);
    send_item(ugob_pkg::OpPlace, 100, 100, 32 * 16 - 1, 3);
    send_item(ugob_pkg::OpPlace, -1, -1, 16, 4);
    send_item(ugob_pkg::OpPlace, -32768, 32767, 0, 5);
    send_item(ugob_pkg::OpPlace, 32767, -32768, 65535, 6);
    send_item(ugob_pkg::OpPlace, 5, 500, 0, 7);
    send_item(ugob_pkg::OpPlace, 10, 10, 0, 0);
    send_item(ugob_pkg::OpQuery, 0, 0, 0, 0);
    send_item(ugob_pkg::OpQuery, 100, 100, 0, 0);
    send_item(ugob_pkg::OpQuery, 132, 100, 0, 0);
    send_item(ugob_pkg::OpQuery, 68, 100, 0, 0);
    send_item(ugob_pkg::OpQuery, 639, 479, 0, 0);
    send_item(ugob_pkg::OpQuery, 40, 0, 0, 0);
    send_item(ugob_pkg::OpQuery, -1, 5, 0, 0);
    send_item(ugob_pkg::OpQuery, 700, 0, 0, 0);
    send_item(ugob_pkg::OpPlace, 300, 300, 0, 2);
    send_item(ugob_pkg::OpQuery, 100, 100, 0, 0);
    send_item(ugob_pkg::OpQuery, 300, 300, 65535, 16'hffff);

    // small grid: overfill one cell so later ids are dropped
    set_grid(64, 64, 16);
    for (int i = 0; i < 18; i++) send_item(ugob_pkg::OpPlace, 20, 20, 0, 100 + i);
    send_item(ugob_pkg::OpQuery, 20, 20, 0, 0);
    for (int i = 0; i < 60; i++) random_item();

    set_grid(640, 480, 32);
    for (int i = 0; i < 60; i++) random_item();
    set_grid(16384, 16384, 4096);
    for (int i = 0; i < 50; i++) random_item();
    set_grid(1, 1, 1);
    for (int i = 0; i < 40; i++) random_item();
    set_grid(32767, 32767, 1);
    for (int i = 0; i < 50; i++) random_item();
    set_grid(100, 100, 0);
    for (int i = 0; i < 50; i++) random_item();
    set_grid(16384, 16384, 8191);
    for (int i = 0; i < 40; i++) random_item();
    set_grid(0, 200, 25);
    for (int i = 0; i < 20; i++) random_item();
    set_grid(200, 160, 20);
    for (int i = 0; i < 60; i++) random_item();

    settle();
    repeat (50) @(negedge clk_i);
    $display("items %0d over nine grid settings, result beats %0d (%0d out of range)",
             n_items, beats, oor_beats);
    $display("cycles %0d, errors %0d, beats left over %0d", cycles, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
